[src/pssp_pkg.sv]
package pssp_pkg;

    localparam int NUM_KEYPOINTS = 8;
    localparam int NUM_STEPS     = 5;
    localparam int KEY_W         = $clog2(NUM_KEYPOINTS);
    localparam int P_W           = 18;
    localparam int T_W           = 32;
    localparam int DVD_W         = P_W + T_W;
    localparam int STEP_W        = 4;
    localparam int FUEL_W        = 16;

    // Slice length is flow_duration / NUM_STEPS by reciprocal multiplication.
    // The four extra fraction bits keep the quotient exact for any 32-bit
    // duration and any step count up to 16.
    localparam int STEP_SHIFT = T_W + 4;
    localparam logic [STEP_SHIFT:0] STEP_RECIP =
        (STEP_SHIFT + 1)'((64'd1 << STEP_SHIFT) / 64'(NUM_STEPS) + 64'd1);

    localparam logic [P_W-1:0]    PMAX        = 18'h3FFFF;
    localparam logic [FUEL_W-1:0] FUEL_SCALE  = 16'd59205;
    localparam logic [P_W-1:0]    FUEL_OFFSET = 18'd3154;

    localparam logic [2:0] MODE_CONST   = 3'd0;
    localparam logic [2:0] MODE_LINEAR  = 3'd1;
    localparam logic [2:0] MODE_PRESS   = 3'd2;
    localparam logic [2:0] MODE_STEPS   = 3'd3;
    localparam logic [2:0] MODE_KEYS    = 3'd4;

    localparam logic [2:0] CFG_MODE       = 3'd0;
    localparam logic [2:0] CFG_SETPOINT   = 3'd1;
    localparam logic [2:0] CFG_RAMP_START = 3'd2;
    localparam logic [2:0] CFG_RAMP_DUR   = 3'd3;
    localparam logic [2:0] CFG_PRESS_DUR  = 3'd4;
    localparam logic [2:0] CFG_PRESS_CUT  = 3'd5;
    localparam logic [2:0] CFG_FLOW_DUR   = 3'd6;
    localparam logic [2:0] CFG_FUEL_SIDE  = 3'd7;

    localparam logic FUNC_EVAL  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic           func;
        logic [T_W-1:0] flow_time;
        logic [2:0]     key_index;
        logic [T_W-1:0] key_time;
        logic [P_W-1:0] key_pressure;
    } t_in;

    typedef struct packed {
        logic [P_W-1:0] pressure_setpoint;
        logic           flow_ended;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_KEY0, S_KEYW, S_SLICE, S_MUL, S_DIV_START, S_DIV_WAIT, S_POST, S_FUEL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_LERP, PH_STEP
    } t_phase;

    // Stepped table in Q10.8: 500, 400, 300, 200, then 150 psi for every later step.
    function automatic logic [P_W-1:0] step_value(input logic [STEP_W-1:0] idx);
        logic [P_W-1:0] v;
        case (idx)
            4'd0:    v = 18'd128000;
            4'd1:    v = 18'd102400;
            4'd2:    v = 18'd76800;
            4'd3:    v = 18'd51200;
            default: v = 18'd38400;
        endcase
        return v;
    endfunction

endpackage

[src/pssp_div.sv]
module pssp_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pssp_pkg::DVD_W-1:0]     i_dividend,
    input  logic [pssp_pkg::T_W-1:0]       i_divisor,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [pssp_pkg::DVD_W-1:0]     o_quot
);

    localparam int CNT_W = $clog2(pssp_pkg::DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pssp_pkg::DVD_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [pssp_pkg::T_W-1:0]    r_rem;
    logic [pssp_pkg::T_W-1:0]    r_dsr;
    logic [pssp_pkg::DVD_W-1:0]  r_q;
    logic [pssp_pkg::T_W:0]      shifted;
    logic                        qbit;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        shifted = {r_rem, r_q[pssp_pkg::DVD_W-1]};
        qbit    = (shifted >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= qbit ? pssp_pkg::T_W'(shifted - {1'b0, r_dsr})
                          : shifted[pssp_pkg::T_W-1:0];
            r_q   <= {r_q[pssp_pkg::DVD_W-2:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[src/pressure_setpoint_profile.sv]
// Pressure setpoint profile generator.
// Input channel (i_in_valid / o_in_stall) carries one word: either an
// evaluate request with a flow time, or a keypoint write. A keypoint write
// is accepted while idle and returns nothing. An evaluate returns exactly one word
// on the output channel (o_out_valid / i_out_stall).
// Constant mode and zero-length segments skip the divider. Ramp and
// keypoint modes run the shared 50-bit restoring divider that retires
// one quotient bit per cycle; keypoint mode first walks the keypoint
// table. Stepped mode gets the slice length from a reciprocal
// multiplication and runs the divider once for the step index.
// The fuel transform adds the S_FUEL state.
// One item is worked on at a time; o_in_stall is high until its result is
// in the output register.
// The result sits in an output register, so a new word can be accepted while
// a result waits on a stalled receiver; a second result waits in the
// sequencer until the first is taken.
// The configuration port (i_cfg_valid / o_cfg_ready) is always ready.
// Synchronous reset clears the configuration registers, the keypoint table,
// the sequencer and the output valid.
module pressure_setpoint_profile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pssp_pkg::t_in       i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pssp_pkg::t_out      o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int P_W = pssp_pkg::P_W;
    localparam int T_W = pssp_pkg::T_W;
    localparam int KEY_W = pssp_pkg::KEY_W;
    localparam int DVD_W = pssp_pkg::DVD_W;
    localparam int SL_W = T_W + pssp_pkg::STEP_SHIFT + 1;
    localparam logic [KEY_W-1:0] KEY_LAST = KEY_W'(pssp_pkg::NUM_KEYPOINTS - 1);
    localparam logic [pssp_pkg::STEP_W-1:0] STEP_LAST =
        pssp_pkg::STEP_W'(pssp_pkg::NUM_STEPS - 1);

    // Configuration registers.
    logic [2:0]     r_mode;
    logic [P_W-1:0] r_setpoint, r_ramp_start, r_press_cut;
    logic [T_W-1:0] r_ramp_dur, r_press_dur, r_flow_dur;
    logic           r_fuel;

    // Keypoint table.
    logic [T_W-1:0] r_key_t [pssp_pkg::NUM_KEYPOINTS];
    logic [P_W-1:0] r_key_p [pssp_pkg::NUM_KEYPOINTS];

    pssp_pkg::t_state r_state, n_state;
    pssp_pkg::t_phase r_phase, n_phase;
    logic [T_W-1:0]   r_t, n_t;
    logic [P_W-1:0]   r_a, n_a;
    logic             r_rise, n_rise;
    logic [P_W-1:0]   r_mag, n_mag;
    logic [T_W-1:0]   r_num, n_num;
    logic [T_W-1:0]   r_den, n_den;
    logic [P_W-1:0]   r_cap, n_cap;
    logic [DVD_W-1:0] r_prod, n_prod;
    logic [KEY_W-1:0] r_idx, n_idx;
    logic [T_W-1:0]   r_t0, n_t0;
    logic [P_W-1:0]   r_p0, n_p0;
    logic [P_W-1:0]   r_val, n_val;
    logic             r_ended, n_ended;
    logic             r_ovalid;
    pssp_pkg::t_out   r_odata;

    logic             dv_start, dv_busy, dv_done;
    logic [DVD_W-1:0] dv_quot;

    logic             in_acc, out_load;
    logic [T_W-1:0]   key_t;
    logic [P_W-1:0]   key_p;
    logic [DVD_W:0]   rise_sum;
    logic [P_W-1:0]   lerp_v;
    logic [19:0]      fuel_v;
    logic [DVD_W-1:0] step_k;
    logic [SL_W-1:0]  slice_prod;
    logic [T_W-1:0]   slice_len;

    pssp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_busy     (dv_busy),
        .o_done     (dv_done),
        .o_quot     (dv_quot)
    );

    assign o_in_stall  = (r_state != pssp_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign key_t       = r_key_t[r_idx];
    assign key_p       = r_key_p[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= pssp_pkg::MODE_CONST;
            r_setpoint   <= '0;
            r_ramp_start <= '0;
            r_ramp_dur   <= '0;
            r_press_dur  <= '0;
            r_press_cut  <= '0;
            r_flow_dur   <= '0;
            r_fuel       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pssp_pkg::CFG_MODE:       r_mode       <= i_cfg_data[2:0];
                pssp_pkg::CFG_SETPOINT:   r_setpoint   <= i_cfg_data[P_W-1:0];
                pssp_pkg::CFG_RAMP_START: r_ramp_start <= i_cfg_data[P_W-1:0];
                pssp_pkg::CFG_RAMP_DUR:   r_ramp_dur   <= i_cfg_data;
                pssp_pkg::CFG_PRESS_DUR:  r_press_dur  <= i_cfg_data;
                pssp_pkg::CFG_PRESS_CUT:  r_press_cut  <= i_cfg_data[P_W-1:0];
                pssp_pkg::CFG_FLOW_DUR:   r_flow_dur   <= i_cfg_data;
                pssp_pkg::CFG_FUEL_SIDE:  r_fuel       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pssp_pkg::NUM_KEYPOINTS; k++) begin
                r_key_t[k] <= '0;
                r_key_p[k] <= '0;
            end
        end else if (in_acc && i_in_data.func == pssp_pkg::FUNC_WRITE
                     && 32'(i_in_data.key_index) < pssp_pkg::NUM_KEYPOINTS) begin
            r_key_t[KEY_W'(i_in_data.key_index)] <= i_in_data.key_time;
            r_key_p[KEY_W'(i_in_data.key_index)] <= i_in_data.key_pressure;
        end
    end

    // Finishing arithmetic for the divider result, the fuel transform, the step index and the slice length.
    always_comb begin
        rise_sum = (DVD_W + 1)'(r_a) + {1'b0, dv_quot};
        if (r_rise) begin
            lerp_v = (rise_sum > (DVD_W + 1)'(pssp_pkg::PMAX)) ? pssp_pkg::PMAX
                                                               : rise_sum[P_W-1:0];
        end else begin
            lerp_v = (dv_quot >= DVD_W'(r_a)) ? '0 : r_a - dv_quot[P_W-1:0];
        end
        if (lerp_v > r_cap) begin
            lerp_v = r_cap;
        end
        fuel_v = 20'((r_prod[33:0] + 34'd32768) >> 16) + 20'(pssp_pkg::FUEL_OFFSET);
        step_k = (dv_quot < DVD_W'(STEP_LAST)) ? dv_quot : DVD_W'(STEP_LAST);
        slice_prod = SL_W'(r_flow_dur) * SL_W'(pssp_pkg::STEP_RECIP);
        slice_len  = T_W'(slice_prod >> pssp_pkg::STEP_SHIFT);
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_t      = r_t;
        n_a      = r_a;
        n_rise   = r_rise;
        n_mag    = r_mag;
        n_num    = r_num;
        n_den    = r_den;
        n_cap    = r_cap;
        n_prod   = r_prod;
        n_idx    = r_idx;
        n_t0     = r_t0;
        n_p0     = r_p0;
        n_val    = r_val;
        n_ended  = r_ended;
        dv_start = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            pssp_pkg::S_IDLE: begin
                if (in_acc && i_in_data.func == pssp_pkg::FUNC_EVAL) begin
                    n_t     = i_in_data.flow_time;
                    n_ended = 1'b0;
                    n_val   = r_setpoint;
                    n_state = pssp_pkg::S_POST;
                    unique case (r_mode)
                        pssp_pkg::MODE_LINEAR: begin
                            if (r_ramp_dur != '0) begin
                                n_a     = r_ramp_start;
                                n_rise  = (r_setpoint >= r_ramp_start);
                                n_mag   = n_rise ? r_setpoint - r_ramp_start
                                                 : r_ramp_start - r_setpoint;
                                n_num   = i_in_data.flow_time;
                                n_den   = r_ramp_dur;
                                n_cap   = r_setpoint;
                                n_state = pssp_pkg::S_MUL;
                            end
                        end
                        pssp_pkg::MODE_PRESS: begin
                            n_val = r_press_cut;
                            if (r_press_dur != '0) begin
                                n_a     = '0;
                                n_rise  = 1'b1;
                                n_mag   = r_setpoint;
                                n_num   = i_in_data.flow_time;
                                n_den   = r_press_dur;
                                n_cap   = r_press_cut;
                                n_state = pssp_pkg::S_MUL;
                            end
                        end
                        pssp_pkg::MODE_STEPS: begin
                            n_state = pssp_pkg::S_SLICE;
                        end
                        pssp_pkg::MODE_KEYS: begin
                            n_idx   = '0;
                            n_state = pssp_pkg::S_KEY0;
                        end
                        default: ;
                    endcase
                end
            end
            pssp_pkg::S_KEY0: begin
                n_t0    = key_t;
                n_p0    = key_p;
                n_idx   = r_idx + 1'b1;
                n_state = pssp_pkg::S_KEYW;
            end
            pssp_pkg::S_KEYW: begin
                if (r_t <= key_t) begin
                    n_state = pssp_pkg::S_POST;
                    if (r_t < r_t0) begin
                        n_val = r_p0;
                    end else if (key_t == r_t0) begin
                        n_val = key_p;
                    end else begin
                        n_a     = r_p0;
                        n_rise  = (key_p >= r_p0);
                        n_mag   = n_rise ? key_p - r_p0 : r_p0 - key_p;
                        n_num   = r_t - r_t0;
                        n_den   = key_t - r_t0;
                        n_cap   = pssp_pkg::PMAX;
                        n_state = pssp_pkg::S_MUL;
                    end
                end else if (r_idx == KEY_LAST) begin
                    n_ended = 1'b1;
                    n_val   = '0;
                    n_state = pssp_pkg::S_POST;
                end else begin
                    n_t0  = key_t;
                    n_p0  = key_p;
                    n_idx = r_idx + 1'b1;
                end
            end
            pssp_pkg::S_SLICE: begin
                if (slice_len == '0) begin
                    n_val   = pssp_pkg::step_value(STEP_LAST);
                    n_state = pssp_pkg::S_POST;
                end else begin
                    n_prod  = DVD_W'(r_t);
                    n_den   = slice_len;
                    n_phase = pssp_pkg::PH_STEP;
                    n_state = pssp_pkg::S_DIV_START;
                end
            end
            pssp_pkg::S_MUL: begin
                n_prod  = DVD_W'(r_mag) * DVD_W'(r_num);
                n_phase = pssp_pkg::PH_LERP;
                n_state = pssp_pkg::S_DIV_START;
            end
            pssp_pkg::S_DIV_START: begin
                dv_start = 1'b1;
                n_state  = pssp_pkg::S_DIV_WAIT;
            end
            pssp_pkg::S_DIV_WAIT: begin
                if (dv_done) begin
                    unique case (r_phase)
                        pssp_pkg::PH_LERP: begin
                            n_val   = lerp_v;
                            n_state = pssp_pkg::S_POST;
                        end
                        default: begin
                            n_val   = pssp_pkg::step_value(step_k[pssp_pkg::STEP_W-1:0]);
                            n_state = pssp_pkg::S_POST;
                        end
                    endcase
                end
            end
            pssp_pkg::S_POST: begin
                if (r_fuel) begin
                    n_prod  = DVD_W'(r_val) * DVD_W'(pssp_pkg::FUEL_SCALE);
                    n_state = pssp_pkg::S_FUEL;
                end else begin
                    n_state = pssp_pkg::S_DONE;
                end
            end
            pssp_pkg::S_FUEL: begin
                n_val   = (fuel_v > 20'(pssp_pkg::PMAX)) ? pssp_pkg::PMAX : fuel_v[P_W-1:0];
                n_state = pssp_pkg::S_DONE;
            end
            pssp_pkg::S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = pssp_pkg::S_IDLE;
                end
            end
            default: n_state = pssp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pssp_pkg::S_IDLE;
            r_phase <= pssp_pkg::PH_LERP;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_a     <= n_a;
        r_rise  <= n_rise;
        r_mag   <= n_mag;
        r_num   <= n_num;
        r_den   <= n_den;
        r_cap   <= n_cap;
        r_prod  <= n_prod;
        r_idx   <= n_idx;
        r_t0    <= n_t0;
        r_p0    <= n_p0;
        r_val   <= n_val;
        r_ended <= n_ended;
        if (out_load) begin
            r_odata.pressure_setpoint <= r_val;
            r_odata.flow_ended        <= r_ended;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // A keypoint write never starts a computation.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.func == pssp_pkg::FUNC_WRITE) |=> r_state == pssp_pkg::S_IDLE)
        else $error("keypoint write left the idle state");

    // The divider is only started when it is free, and only reports back while awaited.
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_start |-> !dv_busy)
        else $error("divider started while busy");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_done |-> r_state == pssp_pkg::S_DIV_WAIT)
        else $error("divider finished outside the wait state");

    // A waiting result is never overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pssp_pkg::S_DONE && r_ovalid && i_out_stall)
        |=> r_state == pssp_pkg::S_DONE)
        else $error("result register overwritten while stalled");

    a_ended_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.flow_ended && !r_fuel) |-> o_out_data.pressure_setpoint == '0)
        else $error("flow ended with a nonzero setpoint");

endmodule
